// ===== hw/rtl/swfrm_pkg.sv =====
// ----------------------------------------------------------------------------
// swfrm_pkg
// Widths and constants shared by the frame rate meter and its divider.
// ----------------------------------------------------------------------------
package swfrm_pkg;

  localparam int STAMP_W = 32;
  localparam int SPAN_W  = 32;
  localparam int WIN_W   = 16;
  localparam int FPS_W   = 20;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd1000;
  localparam logic [FPS_W-1:0] FPS_MAX      = 20'hFFFFF;
  localparam int               FPS_SCALE    = 1000;
  localparam int               SCALE_W      = 10;

endpackage

// ===== hw/rtl/swfrm_divider.sv =====
// ----------------------------------------------------------------------------
// swfrm_divider
// Restoring unsigned divider, one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
module swfrm_divider #(
  parameter int NUM_W = 21
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [NUM_W-1:0]            dividend,
  input  logic [swfrm_pkg::SPAN_W-1:0] divisor,
  output logic                        done,
  output logic [NUM_W-1:0]            quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int REM_W = swfrm_pkg::SPAN_W + 1;

  logic [REM_W-1:0]            rem;
  logic [swfrm_pkg::SPAN_W-1:0] dsor;
  logic [CNT_W-1:0]            bits_left;
  logic                        busy;
  logic [REM_W-1:0]            rem_shift;
  logic [REM_W-1:0]            rem_diff;

  assign rem_shift = {rem[REM_W-2:0], quotient[NUM_W-1]};
  assign rem_diff  = rem_shift - {1'b0, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      done      <= 1'b0;
      bits_left <= '0;
    end else begin
      done <= !start && busy && (bits_left == CNT_W'(1));
      if (start) begin
        busy      <= 1'b1;
        bits_left <= CNT_W'(NUM_W);
        rem       <= '0;
        quotient  <= dividend;
        dsor      <= divisor;
      end else if (busy) begin
        // shift in the next dividend bit, subtract when it fits
        if (!rem_diff[REM_W-1]) begin
          rem      <= rem_diff;
          quotient <= {quotient[NUM_W-2:0], 1'b1};
        end else begin
          rem      <= rem_shift;
          quotient <= {quotient[NUM_W-2:0], 1'b0};
        end
        bits_left <= bits_left - 1'b1;
        if (bits_left == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/sliding_window_frame_rate_meter_core.sv =====
// ----------------------------------------------------------------------------
// sliding_window_frame_rate_meter_core
// Frame rate over a sliding time window, from per-frame millisecond stamps.
// ----------------------------------------------------------------------------
// Each input item (now_ms, restart) is one frame event. The block stores the
// frame's stamp and its span from the previous frame in a ring, evicts frames
// whose age reaches window_ms and returns one fps item per frame:
// 1000 * frames held / summed spans, capped at FPS_MAX, or 0 when the sum is 0.
// Input and output use valid/ready. in_ready is high only while the
// sequencer is idle. An accepted item goes through CHECK, DROP (only when a
// full ring drops its oldest frame first), WRITE, then SCAN and TEST in turn
// for each frame evicted through the ring's registered read port, until the
// scan stops on the newest frame or one still inside the window; then COUNT,
// DIV and DONE. The serial divider works on clog2(RING_DEPTH) + 11 bits, 21
// at the default depth. A zero span sum skips the divider. in_ready returns
// in the same cycle as the fps item. A finished result waits in the output
// register while the next item is taken; if the receiver still stalls when
// that next result is ready, the sequencer holds it until the output register
// frees up. The user must write window_ms through window_we/window_ms only
// while the block is idle; the block itself does not enforce it.
// Reset (rst, synchronous) empties the ring and sets the window to 1000 ms;
// ring contents are not cleared, only entries between tail and head are read.
// ----------------------------------------------------------------------------
module sliding_window_frame_rate_meter_core #(
  parameter int RING_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           window_we,
  input  logic [swfrm_pkg::WIN_W-1:0]    window_ms,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [swfrm_pkg::STAMP_W-1:0]  now_ms,
  input  logic                           restart,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [swfrm_pkg::FPS_W-1:0]    fps
);

  localparam int IW = $clog2(RING_DEPTH);
  localparam int CW = IW + 1;
  localparam int DW = CW + swfrm_pkg::SCALE_W;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_DROP, S_WRITE, S_SCAN, S_TEST, S_COUNT, S_DIV, S_DONE
  } state_t;

  state_t state;

  logic [swfrm_pkg::WIN_W-1:0]   win;
  logic [swfrm_pkg::STAMP_W-1:0] now_q;
  logic [swfrm_pkg::STAMP_W-1:0] prev_stamp;
  logic                          have_prev;
  logic                          empty;
  logic [IW-1:0]                 head;
  logic [IW-1:0]                 tail;
  logic [IW-1:0]                 newest;
  logic [swfrm_pkg::SPAN_W-1:0]  total;
  logic [swfrm_pkg::FPS_W-1:0]   result;
  logic [DW-1:0]                 dividend;
  logic                          div_start;
  logic                          div_done;
  logic [DW-1:0]                 quotient;

  logic [swfrm_pkg::STAMP_W-1:0] stamp_mem [RING_DEPTH];
  logic [swfrm_pkg::SPAN_W-1:0]  span_mem  [RING_DEPTH];
  logic [swfrm_pkg::STAMP_W-1:0] stamp_rd;
  logic [swfrm_pkg::SPAN_W-1:0]  span_rd;

  logic                          mem_we;
  logic [swfrm_pkg::SPAN_W-1:0]  span_new;
  logic [swfrm_pkg::STAMP_W-1:0] age;
  logic [IW-1:0]                 head_next;
  logic [IW-1:0]                 tail_next;
  logic [CW-1:0]                 diff;
  logic [CW-1:0]                 count;

  function automatic logic [IW-1:0] step_slot(input logic [IW-1:0] idx);
    step_slot = (idx == IW'(RING_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign mem_we    = (state == S_WRITE);
  assign span_new  = have_prev ? now_q - prev_stamp : '0;
  assign age       = now_q - stamp_rd;
  assign head_next = step_slot(head);
  assign tail_next = step_slot(tail);

  // frames held between tail and head, a full ring when they meet
  always_comb begin
    diff = {1'b0, head} - {1'b0, tail};
    if (head >= tail) begin
      count = diff;
    end else begin
      count = diff + CW'(RING_DEPTH);
    end
    if (count == '0) begin
      count = CW'(RING_DEPTH);
    end
  end

  // ring storage, the read port always follows the tail
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stamp_mem[head] <= now_q;
      span_mem[head]  <= span_new;
    end
    stamp_rd <= stamp_mem[tail];
    span_rd  <= span_mem[tail];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= swfrm_pkg::WINDOW_RESET;
    end else if (window_we) begin
      win <= window_ms;
    end
  end

  swfrm_divider #(
    .NUM_W (DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (total),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      total      <= '0;
      prev_stamp <= '0;
      have_prev  <= 1'b0;
      empty      <= 1'b1;
      div_start  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      div_start <= (state == S_COUNT) && (total != '0);
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            now_q <= now_ms;
            if (restart) begin
              head       <= '0;
              tail       <= '0;
              total      <= '0;
              prev_stamp <= '0;
              have_prev  <= 1'b0;
              empty      <= 1'b1;
            end
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!empty && head == tail) begin
            state <= S_DROP;
          end else begin
            state <= S_WRITE;
          end
        end
        S_DROP: begin
          // ring full: oldest item goes before the new one lands
          total <= total - span_rd;
          tail  <= tail_next;
          state <= S_WRITE;
        end
        S_WRITE: begin
          total      <= total + span_new;
          newest     <= head;
          head       <= head_next;
          empty      <= 1'b0;
          prev_stamp <= now_q;
          have_prev  <= 1'b1;
          state      <= S_SCAN;
        end
        S_SCAN: begin
          if (tail != newest) begin
            state <= S_TEST;
          end else begin
            state <= S_COUNT;
          end
        end
        S_TEST: begin
          if (age >= {{(swfrm_pkg::STAMP_W - swfrm_pkg::WIN_W){1'b0}}, win}) begin
            total <= total - span_rd;
            tail  <= tail_next;
            state <= S_SCAN;
          end else begin
            state <= S_COUNT;
          end
        end
        S_COUNT: begin
          if (total == '0) begin
            result <= '0;
            state  <= S_DONE;
          end else begin
            dividend <= DW'(count) * DW'(swfrm_pkg::FPS_SCALE);
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (64'(quotient) > 64'(swfrm_pkg::FPS_MAX)) begin
              result <= swfrm_pkg::FPS_MAX;
            end else begin
              result <= swfrm_pkg::FPS_W'(quotient);
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            fps       <= result;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sliding window frame rate meter.
// ----------------------------------------------------------------------------
// Frame items go in through a valid/ready sender with random gaps. Each fps
// item that comes out is compared with a prediction from a behavioral copy of
// the stamp/span ring. Directed tests cover first frames, restart, stamp
// wrap, extreme windows and a full ring. They are followed by random frame
// sequences under a range of window settings.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RING_SLOTS = 1024;
  localparam int SLOT_W     = $clog2(RING_SLOTS);

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          window_we = 1'b0;
  logic [swfrm_pkg::WIN_W-1:0]   window_ms = '0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  logic [swfrm_pkg::STAMP_W-1:0] now_ms    = '0;
  logic                          restart   = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [swfrm_pkg::FPS_W-1:0]   fps;

  always #5 clk = ~clk;

  sliding_window_frame_rate_meter_core #(
    .RING_DEPTH(RING_SLOTS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .window_we(window_we),
    .window_ms(window_ms),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .now_ms(now_ms),
    .restart(restart),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .fps(fps)
  );

  // behavioral copy of the frame ring
  logic [swfrm_pkg::STAMP_W-1:0] stamp_hist [RING_SLOTS];
  logic [swfrm_pkg::SPAN_W-1:0]  span_hist  [RING_SLOTS];
  logic [SLOT_W-1:0]             head_slot;
  logic [SLOT_W-1:0]             tail_slot;
  logic [swfrm_pkg::SPAN_W-1:0]  span_sum;
  logic [swfrm_pkg::STAMP_W-1:0] last_stamp;
  logic                          have_last;
  logic                          ring_vacant;
  logic [swfrm_pkg::WIN_W-1:0]   window_len;

  logic [swfrm_pkg::FPS_W-1:0] fps_expected [$];
  int mismatch_count = 0;
  bit tx_gaps = 1'b0;
  bit rx_stalls = 1'b0;
  int rx_hold = 0;

  function automatic void clear_history();
    head_slot   = '0;
    tail_slot   = '0;
    span_sum    = '0;
    last_stamp  = '0;
    have_last   = 1'b0;
    ring_vacant = 1'b1;
  endfunction

  function automatic logic [swfrm_pkg::FPS_W-1:0] predict_fps(
    logic [swfrm_pkg::STAMP_W-1:0] stamp,
    logic                          fresh
  );
    logic [swfrm_pkg::SPAN_W-1:0]  span;
    logic [swfrm_pkg::STAMP_W-1:0] age;
    logic [SLOT_W-1:0]             newest;
    logic [SLOT_W:0]               held;
    logic [63:0]                   quotient;
    if (fresh) clear_history();
    // ring full: oldest frame makes room first
    if (!ring_vacant && head_slot == tail_slot) begin
      span_sum -= span_hist[tail_slot];
      tail_slot++;
    end
    span = have_last ? stamp - last_stamp : '0;
    stamp_hist[head_slot] = stamp;
    span_hist[head_slot]  = span;
    span_sum += span;
    newest = head_slot;
    head_slot++;
    ring_vacant = 1'b0;
    last_stamp  = stamp;
    have_last   = 1'b1;
    age = stamp - stamp_hist[tail_slot];
    while (tail_slot != newest && age >= window_len) begin
      span_sum -= span_hist[tail_slot];
      tail_slot++;
      age = stamp - stamp_hist[tail_slot];
    end
    held = {1'b0, head_slot - tail_slot};
    if (held == 0) held = (SLOT_W + 1)'(RING_SLOTS);
    if (span_sum == 0) return '0;
    quotient = (64'(swfrm_pkg::FPS_SCALE) * held) / span_sum;
    return (quotient > swfrm_pkg::FPS_MAX) ? swfrm_pkg::FPS_MAX
                                           : quotient[swfrm_pkg::FPS_W-1:0];
  endfunction

  // mostly no pause, sometimes short, now and then long
  function automatic int pick_pause();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  always @(negedge clk) begin
    if (!rx_stalls) begin
      out_ready <= 1'b1;
    end else if (rx_hold > 0) begin
      rx_hold   = rx_hold - 1;
      out_ready <= 1'b0;
    end else begin
      rx_hold = pick_pause();
      out_ready <= (rx_hold == 0);
    end
  end

  always @(posedge clk) begin : fps_check
    logic [swfrm_pkg::FPS_W-1:0] want;
    if (!rst && out_valid && out_ready) begin
      if (fps_expected.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: fps item %0d with none expected", $time, fps);
        mismatch_count++;
      end else begin
        want = fps_expected.pop_front();
        if (fps !== want) begin
          if (mismatch_count < 10)
            $display("%0t: fps expected %0d, got %0d", $time, want, fps);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_frame(logic [swfrm_pkg::STAMP_W-1:0] stamp, logic fresh);
    int gap;
    gap = tx_gaps ? pick_pause() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    fps_expected.push_back(predict_fps(stamp, fresh));
    in_valid <= 1'b1;
    now_ms   <= stamp;
    restart  <= fresh;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (fps_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic set_window(logic [swfrm_pkg::WIN_W-1:0] len);
    hold_until_drained();
    @(negedge clk);
    window_we <= 1'b1;
    window_ms <= len;
    @(negedge clk);
    window_we <= 1'b0;
    window_len = len;
  endtask

  task automatic test_first_frames();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    send_frame(32'd0, 1'b0);
    send_frame(32'd0, 1'b0);
    send_frame(32'd10, 1'b0);
    send_frame(32'd1009, 1'b0);
    send_frame(32'hFFFF_FFFF, 1'b0);
    send_frame(32'd3, 1'b0);          // stamp wraps through zero
    send_frame(32'd5, 1'b1);
    send_frame(32'd5, 1'b0);
    send_frame(32'd6, 1'b1);
    send_frame(32'd7, 1'b0);
    send_frame(32'hAAAA_AAAA, 1'b1);
    send_frame(32'hAAAA_AAAB, 1'b0);
    send_frame(32'h5555_5555, 1'b0);
  endtask

  task automatic test_window_extremes();
    rx_stalls = 1'b1;
    set_window(16'd1);
    send_frame(32'd100, 1'b1);
    send_frame(32'd100, 1'b0);
    send_frame(32'd101, 1'b0);
    send_frame(32'd101, 1'b0);
    set_window(16'hFFFF);
    send_frame(32'd0, 1'b1);
    send_frame(32'd65534, 1'b0);
    send_frame(32'd65535, 1'b0);
    send_frame(32'd65600, 1'b0);
    set_window(16'h5555);
    send_frame(32'h1234_0000, 1'b1);
    send_frame(32'h1234_0010, 1'b0);
    set_window(16'hAAAA);
    send_frame(32'h1234_0020, 1'b0);
    send_frame(32'h1234_B000, 1'b0);
    set_window(swfrm_pkg::WINDOW_RESET);
  endtask

  task automatic test_full_ring();
    logic [swfrm_pkg::STAMP_W-1:0] base;
    base = $urandom;
    set_window(16'hFFFF);
    tx_gaps   = 1'b0;
    rx_stalls = 1'b1;
    // a full ring of equal stamps and one 1 ms span gives the top rate
    send_frame(base, 1'b1);
    repeat (RING_SLOTS - 2) send_frame(base, 1'b0);
    repeat (8) send_frame(base + 32'd1, 1'b0);
    send_frame(base + 32'd2, 1'b0);
    // long jump empties the ring down to the newest frame
    send_frame(base + 32'd70000, 1'b0);
    send_frame(base + 32'd70001, 1'b0);
    hold_until_drained();
  endtask

  task automatic test_random_traffic(int item_goal);
    int sent;
    int roll;
    int seq_len;
    int step_cap;
    logic [swfrm_pkg::STAMP_W-1:0] stamp;
    logic fresh;
    sent = 0;
    while (sent < item_goal) begin
      roll = $urandom_range(99);
      if (roll < 12)      set_window(16'd1);
      else if (roll < 24) set_window(16'hFFFF);
      else if (roll < 44) set_window(16'($urandom_range(64, 1)));
      else if (roll < 64) set_window(16'($urandom_range(5000, 100)));
      else if (roll < 75) set_window(16'($urandom_range(65535, 1)));
      else if (roll < 85) hold_until_drained();
      tx_gaps   = ($urandom_range(3) != 0);
      rx_stalls = ($urandom_range(3) != 0);
      stamp = ($urandom_range(3) == 0) ? 32'hFFFF_FF00 + $urandom_range(255) : $urandom;
      seq_len  = $urandom_range(60, 5);
      step_cap = window_len / 8 + 1;
      send_frame(stamp, 1'($urandom_range(1)));
      sent++;
      for (int k = 1; k < seq_len && sent < item_goal; k++) begin
        roll  = $urandom_range(99);
        fresh = 1'b0;
        if (roll < 3) begin
          stamp = $urandom;
        end else if (roll < 8) begin
          fresh = 1'b1;
          stamp = stamp + $urandom_range(step_cap);
        end else if (roll < 78) begin
          stamp = stamp + $urandom_range(step_cap);
        end else if (roll < 93) begin
          stamp = stamp + $urandom_range(2 * window_len + 2);
        end
        send_frame(stamp, fresh);
        sent++;
      end
    end
  endtask

  initial begin
    clear_history();
    window_len = swfrm_pkg::WINDOW_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_first_frames();
    test_window_extremes();
    test_full_ring();
    test_random_traffic(400);
    hold_until_drained();
    repeat (64) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sliding_window_frame_rate_meter_core.f =====
hw/rtl/swfrm_pkg.sv
hw/rtl/swfrm_divider.sv
hw/rtl/sliding_window_frame_rate_meter_core.sv
tb/sv/testbench.sv
